[rtl/kes_pkg.sv]
package kes_pkg;

    localparam int FRAC_BITS_DEF    = 26;
    localparam int CORDIC_STEPS_DEF = 28;

    localparam int ECC_W   = 27;
    localparam int ANGLE_W = 31;
    localparam int TOL_W   = 27;
    localparam int ITER_W  = 12;
    localparam int CFG_W   = 31;
    localparam int FVAL_W  = 34;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] GAIN_Q30 = 64'd652032874;

    localparam logic [ANGLE_W-1:0] BRACKET_LOW_RST  = 31'd0;
    localparam logic [ANGLE_W-1:0] BRACKET_HIGH_RST = 31'd1677721600;
    localparam logic [TOL_W-1:0]   TOLERANCE_RST    = 27'd7;
    localparam logic [ITER_W-1:0]  MAX_ITER_RST     = 12'd1000;

    typedef enum logic [1:0] {
        REG_BRACKET_LOW  = 2'd0,
        REG_BRACKET_HIGH = 2'd1,
        REG_TOLERANCE    = 2'd2,
        REG_MAX_ITER     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [ECC_W-1:0]   eccentricity;
        logic [ANGLE_W-1:0] mean_anomaly;
    } kes_in_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] eccentric_anomaly;
        logic [ITER_W-1:0]  iterations_used;
        logic               limit_reached;
    } kes_out_t;

    // status of one evaluation of f(E) = E - e*sin(E) - M
    typedef struct packed {
        logic done;
        logic neg;
        logic zero;
    } fval_res_t;

    // elaboration-time helpers
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], n[k]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) in Q62 by series
    function automatic logic [63:0] atan_q62(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int ex;
        sum = '0;
        if (i == 0) begin
            sum = PI_Q60;
        end
        else begin
            for (int k = 0; k < 32; k++) begin
                ex = i * (2 * k + 1);
                if (ex <= 62) begin
                    term = udiv64(64'd1 << (62 - ex), 64'(2 * k + 1));
                    if (k % 2 == 1) begin
                        sum = sum - term;
                    end
                    else begin
                        sum = sum + term;
                    end
                end
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] rnd_shift(input logic [63:0] v, input int sh);
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic logic [63:0] atan_q(input int i, input int frac);
        return rnd_shift(atan_q62(i), 62 - frac);
    endfunction

    function automatic logic [63:0] pi_q(input int frac);
        return rnd_shift(PI_Q60, 60 - frac);
    endfunction

    function automatic logic [63:0] two_pi_q(input int frac);
        return rnd_shift(PI_Q60 << 1, 60 - frac);
    endfunction

    function automatic logic [63:0] half_pi_q(input int frac);
        return rnd_shift(PI_Q60, 61 - frac);
    endfunction

    function automatic logic [63:0] gain_q(input int frac);
        logic [63:0] g;
        if (frac < 30) begin
            g = rnd_shift(GAIN_Q30, 30 - frac);
        end
        else begin
            g = GAIN_Q30 << (frac - 30);
        end
        return g;
    endfunction

endpackage

[rtl/kepler_equation_bisection_solver.sv]
// Kepler equation solver: finds E with E - e*sin(E) = M by bisection over a
// programmed bracket, all angles unsigned Q5.26 radians.
// in channel: in_valid/in_ready, payload in_data (eccentricity, mean anomaly).
// out channel: out_valid/out_ready, payload out_data (last midpoint,
// number of halvings, limit flag). One result per input item.
// cfg port: cfg_we with cfg_index selects bracket_low, bracket_high,
// tolerance or max_iterations; write only while no solve is in flight.
// Each function evaluation runs on one shared sequential unit: modulo 2*pi
// by shift-subtract, fold, CORDIC_STEPS rotations, multiply, sign test.
// A solve with n halvings needs n + 1 evaluations.
// A bracket already narrower than the tolerance skips the evaluations:
// the transfer goes straight to the finish state, which fills the output
// register once it is free; the block then goes idle for the next item.
// in_ready is high only while no solve runs; a finished result is held in
// the output register, and a new item may be taken while it waits.
// A stalled receiver holds the next result inside the block until taken.
// Reset restores the register defaults and empties the output register.
module kepler_equation_bisection_solver #(
    parameter int FRAC_BITS    = kes_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = kes_pkg::CORDIC_STEPS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  kes_pkg::kes_in_t            in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output kes_pkg::kes_out_t           out_data,
    input  logic                        cfg_we,
    input  kes_pkg::cfg_index_t         cfg_index,
    input  logic [kes_pkg::CFG_W-1:0]   cfg_data
);
    import kes_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EVAL_A = 5'b00010,
        S_MID    = 5'b00100,
        S_EVAL_S = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [ANGLE_W-1:0] bracket_low_reg, bracket_high_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic [ITER_W-1:0]  max_iter_reg;

    logic [ANGLE_W-1:0] a_reg, b_reg, s_reg;
    logic [ECC_W-1:0]   ecc_reg;
    logic [ANGLE_W-1:0] nt_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [ITER_W-1:0]  maxit_reg;
    logic [ITER_W-1:0]  iters_reg;
    logic               limit_reg;
    logic               sa_neg_reg, sa_zero_reg;
    logic               out_valid_reg;
    kes_out_t           out_reg;

    fval_res_t          fres;
    logic               fstart;
    logic [ANGLE_W-1:0] farg;

    function automatic logic [ANGLE_W-1:0] mid_of(input logic [ANGLE_W-1:0] x,
                                                  input logic [ANGLE_W-1:0] y);
        logic [ANGLE_W:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        return sum[ANGLE_W:1];
    endfunction

    function automatic logic wide_of(input logic [ANGLE_W-1:0] x,
                                     input logic [ANGLE_W-1:0] y,
                                     input logic [TOL_W-1:0] t);
        logic [ANGLE_W-1:0] w;
        w = (x > y) ? x - y : y - x;
        return w >= ANGLE_W'(t);
    endfunction

    logic               start_wide;
    logic               take_b;
    logic [ANGLE_W-1:0] a_new, b_new;
    logic               new_wide;
    logic               at_limit;

    assign start_wide = wide_of(bracket_low_reg, bracket_high_reg, tolerance_reg);
    assign take_b = fres.zero || sa_zero_reg || (fres.neg != sa_neg_reg);
    assign a_new  = take_b ? a_reg : s_reg;
    assign b_new  = take_b ? s_reg : b_reg;
    assign new_wide = wide_of(a_new, b_new, tol_reg);
    assign at_limit = (iters_reg >= maxit_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign fstart = (state_reg == S_IDLE && in_valid && start_wide) || (state_reg == S_MID);
    assign farg   = (state_reg == S_IDLE) ? bracket_low_reg : mid_of(a_reg, b_reg);

    kes_fval #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_fval (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fstart),
        .arg   (farg),
        .ecc   (ecc_reg),
        .nt    (nt_reg),
        .res   (fres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bracket_low_reg  <= BRACKET_LOW_RST;
            bracket_high_reg <= BRACKET_HIGH_RST;
            tolerance_reg    <= TOLERANCE_RST;
            max_iter_reg     <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BRACKET_LOW:  bracket_low_reg  <= cfg_data[ANGLE_W-1:0];
                REG_BRACKET_HIGH: bracket_high_reg <= cfg_data[ANGLE_W-1:0];
                REG_TOLERANCE:    tolerance_reg    <= cfg_data[TOL_W-1:0];
                REG_MAX_ITER:     max_iter_reg     <= cfg_data[ITER_W-1:0];
                default:          max_iter_reg     <= max_iter_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid) state_next = start_wide ? S_EVAL_A : S_FINISH;
            S_EVAL_A:
                if (fres.done) state_next = S_MID;
            S_MID:
                state_next = S_EVAL_S;
            S_EVAL_S:
                if (fres.done) state_next = (at_limit || !new_wide) ? S_FINISH : S_MID;
            S_FINISH:
                if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            iters_reg     <= '0;
            maxit_reg     <= MAX_ITER_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FINISH && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && in_valid)
            begin
                iters_reg <= '0;
                // a zero limit acts as one halving
                maxit_reg <= (max_iter_reg == '0) ? ITER_W'(1) : max_iter_reg;
            end
            else if (state_reg == S_MID)
            begin
                iters_reg <= iters_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_reg     <= bracket_low_reg;
                    b_reg     <= bracket_high_reg;
                    s_reg     <= mid_of(bracket_low_reg, bracket_high_reg);
                    ecc_reg   <= in_data.eccentricity;
                    nt_reg    <= in_data.mean_anomaly;
                    tol_reg   <= tolerance_reg;
                    limit_reg <= 1'b0;
                end
            end
            S_EVAL_A:
            begin
                if (fres.done)
                begin
                    sa_neg_reg  <= fres.neg;
                    sa_zero_reg <= fres.zero;
                end
            end
            S_MID:
            begin
                s_reg <= mid_of(a_reg, b_reg);
            end
            S_EVAL_S:
            begin
                if (fres.done)
                begin
                    a_reg     <= a_new;
                    b_reg     <= b_new;
                    limit_reg <= new_wide;
                    // kept end moved to the midpoint, so its sign is known
                    if (!take_b)
                    begin
                        sa_neg_reg  <= fres.neg;
                        sa_zero_reg <= fres.zero;
                    end
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.eccentric_anomaly <= s_reg;
                    out_reg.iterations_used   <= iters_reg;
                    out_reg.limit_reached     <= limit_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        fres.done |-> (state_reg == S_EVAL_A || state_reg == S_EVAL_S))
        else $error("evaluation finished outside an evaluation state");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> iters_reg <= maxit_reg)
        else $error("halving count passed the limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while a solve is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MID |=> !fres.done)
        else $error("evaluation finished without running");
`endif

endmodule

[rtl/kes_fval.sv]
module kes_fval #(
    parameter int FRAC_BITS    = kes_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = kes_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kes_pkg::ANGLE_W-1:0]   arg,
    input  logic [kes_pkg::ECC_W-1:0]     ecc,
    input  logic [kes_pkg::ANGLE_W-1:0]   nt,
    output kes_pkg::fval_res_t            res
);
    import kes_pkg::*;

    localparam int QB   = (FRAC_BITS >= 29) ? 1 : 30 - FRAC_BITS;
    localparam int RW   = FRAC_BITS + 3 + QB;
    localparam int CW   = FRAC_BITS + 3;
    localparam int FW   = FRAC_BITS + 4;
    localparam int PW   = ECC_W + CW - 1;
    localparam int QCW  = (QB > 1) ? $clog2(QB) : 1;
    localparam int SW   = $clog2(CORDIC_STEPS);

    localparam logic [RW-1:0]        MOD_TOP = RW'(two_pi_q(FRAC_BITS)) << (QB - 1);
    localparam logic signed [FW-1:0] PI_S    = FW'(pi_q(FRAC_BITS));
    localparam logic signed [FW-1:0] TWO_PI_S = FW'(two_pi_q(FRAC_BITS));
    localparam logic signed [FW-1:0] HALF_PI_S = FW'(half_pi_q(FRAC_BITS));
    localparam logic signed [CW-1:0] GAIN_S  = CW'(gain_q(FRAC_BITS));
    localparam logic [PW-1:0]        HALF_LSB = PW'(1) << (FRAC_BITS - 1);
    localparam logic [QCW-1:0]       QCNT_TOP = QCW'(QB - 1);
    localparam logic [SW-1:0]        STEP_LAST = SW'(CORDIC_STEPS - 1);

    typedef enum logic [5:0] {
        F_IDLE   = 6'b000001,
        F_REDUCE = 6'b000010,
        F_FOLD   = 6'b000100,
        F_ROTATE = 6'b001000,
        F_MULT   = 6'b010000,
        F_SIGN   = 6'b100000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [ANGLE_W-1:0]    arg_reg;
    logic [RW-1:0]         rem_reg;
    logic [RW-1:0]         mod_reg;
    logic [QCW-1:0]        qcnt_reg;
    logic [SW-1:0]         step_reg;
    logic signed [CW-1:0]  x_reg, y_reg, z_reg;
    logic [PW-1:0]         prod_reg;
    logic                  yneg_reg;

    logic signed [CW-1:0]  atan_tab [CORDIC_STEPS];

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_atan
        assign atan_tab[g] = CW'(atan_q(g, FRAC_BITS));
    end

    logic signed [FW-1:0]  r0, r1, r2;
    logic signed [CW-1:0]  dx, dy, ang;
    logic signed [CW-1:0]  yneg_val;
    logic [CW-2:0]         ymag;
    logic [FVAL_W-1:0]     l_ext, p_ext, nt_ext, f_val;

    always_comb
    begin
        // fold the reduced angle into [-pi/2, pi/2]
        r0 = {1'b0, rem_reg[FRAC_BITS+2:0]};
        r1 = (r0 > PI_S) ? r0 - TWO_PI_S : r0;
        if (r1 > HALF_PI_S)
        begin
            r2 = PI_S - r1;
        end
        else if (r1 < -HALF_PI_S)
        begin
            r2 = -PI_S - r1;
        end
        else
        begin
            r2 = r1;
        end
    end

    assign dx   = y_reg >>> step_reg;
    assign dy   = x_reg >>> step_reg;
    assign ang  = atan_tab[step_reg];
    assign yneg_val = -y_reg;
    assign ymag = y_reg[CW-1] ? yneg_val[CW-2:0] : y_reg[CW-2:0];

    assign l_ext  = FVAL_W'(arg_reg);
    assign nt_ext = FVAL_W'(nt);
    assign p_ext  = FVAL_W'(prod_reg[PW-1:FRAC_BITS]);
    assign f_val  = yneg_reg ? l_ext + p_ext - nt_ext : l_ext - p_ext - nt_ext;

    assign res.done = (state_reg == F_SIGN);
    assign res.neg  = f_val[FVAL_W-1];
    assign res.zero = (f_val == '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:   if (start) state_next = F_REDUCE;
            F_REDUCE: if (qcnt_reg == '0) state_next = F_FOLD;
            F_FOLD:   state_next = F_ROTATE;
            F_ROTATE: if (step_reg == STEP_LAST) state_next = F_MULT;
            F_MULT:   state_next = F_SIGN;
            F_SIGN:   state_next = F_IDLE;
            default:  state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                arg_reg  <= arg;
                rem_reg  <= RW'(arg);
                mod_reg  <= MOD_TOP;
                qcnt_reg <= QCNT_TOP;
            end
            F_REDUCE:
            begin
                if (rem_reg >= mod_reg)
                begin
                    rem_reg <= rem_reg - mod_reg;
                end
                mod_reg  <= mod_reg >> 1;
                qcnt_reg <= qcnt_reg - 1'b1;
            end
            F_FOLD:
            begin
                z_reg    <= r2[CW-1:0];
                x_reg    <= GAIN_S;
                y_reg    <= '0;
                step_reg <= '0;
            end
            F_ROTATE:
            begin
                if (!z_reg[CW-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - ang;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + ang;
                end
                step_reg <= step_reg + 1'b1;
            end
            F_MULT:
            begin
                prod_reg <= PW'(ecc) * PW'(ymag) + HALF_LSB;
                yneg_reg <= y_reg[CW-1];
            end
            default:
            begin
            end
        endcase
    end

endmodule

[test/kepler_equation_bisection_solver_tb.sv]
module kepler_equation_bisection_solver_tb;
    import kes_pkg::*;

    localparam int  STALL_LIMIT = 800000;
    localparam int  HOLD_CYCLES = 3000;
    localparam longint ANGLE_MAX = 1677721600;

    class kepler_scoreboard;
        kes_out_t  anomaly_q[$];
        longint    lo_end, hi_end, tol, iter_cap;
        longint    atan_tab[64];
        longint    pi_v, two_pi_v, half_pi_v, gain_v;
        int        errors;
        int        results_seen;

        function new();
            logic [63:0] acc, term;
            int ex;
            lo_end   = BRACKET_LOW_RST;
            hi_end   = BRACKET_HIGH_RST;
            tol      = TOLERANCE_RST;
            iter_cap = MAX_ITER_RST;
            errors   = 0;
            results_seen = 0;
            atan_tab[0] = longint'((PI_Q60 + (64'd1 << 35)) >> 36);
            for (int i = 1; i < 64; i++)
            begin
                acc = 0;
                for (int k = 0; k < 32; k++)
                begin
                    ex = i * (2 * k + 1);
                    if (ex > 62)
                        break;
                    term = (64'd1 << (62 - ex)) / 64'(2 * k + 1);
                    acc = (k % 2 == 1) ? acc - term : acc + term;
                end
                atan_tab[i] = longint'((acc + (64'd1 << 35)) >> 36);
            end
            pi_v      = longint'((PI_Q60 + (64'd1 << 33)) >> 34);
            two_pi_v  = longint'(((PI_Q60 << 1) + (64'd1 << 33)) >> 34);
            half_pi_v = longint'((PI_Q60 + (64'd1 << 34)) >> 35);
            gain_v    = longint'((GAIN_Q30 + 64'd8) >> 4);
        endfunction

        function void set_reg(cfg_index_t idx, longint v);
            case (idx)
                REG_BRACKET_LOW:  lo_end   = v & ((64'd1 << 31) - 1);
                REG_BRACKET_HIGH: hi_end   = v & ((64'd1 << 31) - 1);
                REG_TOLERANCE:    tol      = v & ((64'd1 << 27) - 1);
                REG_MAX_ITER:     iter_cap = v & ((64'd1 << 12) - 1);
                default: ;
            endcase
        endfunction

        // residual of e - ecc*sin(e) - m, cordic sine after range fold
        function longint kepler_residual(longint ang, longint ecc, longint m);
            longint r, x, y, z, dx, dy, mag, prod;
            r = ang % two_pi_v;
            if (r > pi_v)
                r -= two_pi_v;
            if (r > half_pi_v)
                r = pi_v - r;
            else if (r < -half_pi_v)
                r = -pi_v - r;
            z = r;
            x = gain_v;
            y = 0;
            for (int i = 0; i < 28; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end
                else
                begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            mag  = (y < 0) ? -y : y;
            prod = (ecc * mag + (64'sd1 <<< 25)) >>> 26;
            if (y < 0)
                prod = -prod;
            return ang - prod - m;
        endfunction

        function int sgn(longint v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function void note_input(kes_in_t item);
            longint a, b, mid, width, ecc, m;
            int    iters, sm, sa;
            kes_out_t res;
            ecc = item.eccentricity;
            m   = item.mean_anomaly;
            a = lo_end;
            b = hi_end;
            mid = (a + b) >>> 1;
            iters = 0;
            width = (a > b) ? a - b : b - a;
            while (width >= tol)
            begin
                iters++;
                mid = (a + b) >>> 1;
                sm = sgn(kepler_residual(mid, ecc, m));
                sa = sgn(kepler_residual(a, ecc, m));
                if (sm == 0 || sa == 0 || sm != sa)
                    b = mid;
                else
                    a = mid;
                width = (a > b) ? a - b : b - a;
                if (iters >= iter_cap)
                    break;
            end
            res.eccentric_anomaly = mid[ANGLE_W-1:0];
            res.iterations_used   = iters[ITER_W-1:0];
            res.limit_reached     = (width >= tol);
            anomaly_q.push_back(res);
        endfunction

        function void check_result(kes_out_t got);
            kes_out_t want;
            results_seen++;
            if (anomaly_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = anomaly_q.pop_front();
            if (got.eccentric_anomaly !== want.eccentric_anomaly)
            begin
                $display("%0t: eccentric_anomaly expected %0d actual %0d", $time,
                         want.eccentric_anomaly, got.eccentric_anomaly);
                errors++;
            end
            if (got.iterations_used !== want.iterations_used)
            begin
                $display("%0t: iterations_used expected %0d actual %0d", $time,
                         want.iterations_used, got.iterations_used);
                errors++;
            end
            if (got.limit_reached !== want.limit_reached)
            begin
                $display("%0t: limit_reached expected %0b actual %0b", $time,
                         want.limit_reached, got.limit_reached);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    kes_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    kes_out_t    out_data;
    logic        cfg_we;
    cfg_index_t  cfg_index;
    logic [CFG_W-1:0] cfg_data;

    kepler_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req;
    int  quiet_cycles;
    int  items_sent;

    kepler_equation_bisection_solver DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // transfer monitors and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int n;
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_req = 0;
            end
            out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(cfg_index_t idx, longint v);
        @(negedge clk);
        cfg_we    = 1;
        cfg_index = idx;
        cfg_data  = v[CFG_W-1:0];
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic set_bracket(longint lo, longint hi, longint t, longint cap);
        write_reg(REG_BRACKET_LOW, lo);
        write_reg(REG_BRACKET_HIGH, hi);
        write_reg(REG_TOLERANCE, t);
        write_reg(REG_MAX_ITER, cap);
    endtask

    task automatic send_item(longint ecc, longint m);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 0;
            @(negedge clk);
        end
        in_valid = 1;
        in_data.eccentricity = ecc[ECC_W-1:0];
        in_data.mean_anomaly = m[ANGLE_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 0;
        while (sb.anomaly_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    function automatic longint rand_ecc();
        case ($urandom_range(3))
            0: return $urandom_range(67108864);
            1: return $urandom_range((1 << 27) - 1);
            2: return $urandom_range(16777216);
            default: return 67108864 - $urandom_range(4096);
        endcase
    endfunction

    function automatic longint rand_angle();
        if ($urandom_range(9) == 0)
            return $urandom_range(32'h7fffffff);
        return $urandom_range(ANGLE_MAX);
    endfunction

    initial
    begin
        longint lo, hi;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_index = REG_BRACKET_LOW;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 0;
        quiet_cycles = 0;
        items_sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // default bracket: field extremes
        send_item(0, 0);
        send_item(67108864, 0);
        send_item((1 << 27) - 1, ANGLE_MAX);
        send_item(67108864, ANGLE_MAX);
        send_item(33554432, 32'h7fffffff);
        send_item(0, 105414357);
        drain();
        // narrow bracket returns its midpoint at once
        set_bracket(1000, 1003, 7, 1000);
        send_item(33554432, 5000);
        send_item(0, 0);
        drain();
        // reversed bracket, wide tolerance
        set_bracket(ANGLE_MAX, 0, 67108864, 1000);
        send_item(67108864, 210828714);
        send_item(12345678, ANGLE_MAX);
        drain();
        // zero tolerance runs to the limit
        set_bracket(0, ANGLE_MAX, 0, 40);
        send_item(50000000, 300000000);
        send_item(0, 0);
        drain();
        // zero limit acts as one halving
        set_bracket(0, 32'h7fffffff, 1, 0);
        send_item(67108864, 800000000);
        drain();
        // largest limit, reached by the first item only
        set_bracket(0, 0, 0, 4095);
        send_item(40000000, 0);
        drain();
        set_bracket(32'h7fffffff, 0, (1 << 27) - 1, 4095);
        send_item(20000000, 400000000);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 33 : ((phase == 1) ? 84 : 0);
            recv_idle_pct = (phase == 0) ? 84 : ((phase == 1) ? 33 : 0);
            for (int sub = 0; sub < 4; sub++)
            begin
                lo = (sub == 0) ? 0 : rand_angle();
                hi = (sub == 0) ? ANGLE_MAX : rand_angle();
                set_bracket(lo, hi, longint'(1) << $urandom_range(26, 6),
                            $urandom_range(1, 40));
                if (sub == 1)
                    hold_req = 1;
                for (int k = 0; k < 49; k++)
                    send_item(rand_ecc(), rand_angle());
                drain();
            end
        end

        $display("covered %0d solves over directed bracket corners and 12 random settings",
                 items_sent);
        $display("%0d results checked, %0d mismatches", sb.results_seen, sb.errors);
        if (sb.errors == 0 && sb.anomaly_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
